/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hdu_pkg.sv */
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants of the half-duplex 8N1 UART.
// ----------------------------------------------------------------------------
package hdu_pkg;

    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int BYTE_W     = 8;
    localparam int FRAME_W    = 10;
    localparam int CNT_W      = 4;
    localparam int MODE_W     = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS = 1'd1;

    localparam logic [TICK_W-1:0] BIT_TICKS_RST  = 16'd104;
    localparam logic [TICK_W-1:0] HALF_TICKS_RST = 16'd52;

    // line modes
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RX   = 2'd2;

    localparam logic [CNT_W-1:0]   TX_STEPS    = 4'd11;
    localparam logic [CNT_W-1:0]   RX_SAMPLES  = 4'd10;
    localparam logic [FRAME_W-1:0] FRAME_MASK  = 10'h201;
    localparam logic [FRAME_W-1:0] STOP_MARK   = 10'h200;

    typedef struct packed {
        logic [BYTE_W-1:0] send_byte;
        logic              send;
        logic              rx_level;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              rx_busy;
        logic              tx_busy;
        logic              tx_level;
    } result_t;

endpackage

/* rtl/core/hdu_in_stage.sv */
// ----------------------------------------------------------------------------
// hdu_in_stage
// Input register: holds one tick item until the core consumes it.
// ----------------------------------------------------------------------------
module hdu_in_stage
    import hdu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  advance,   // core consumes the held item
    output logic                  item_vld,
    output item_t                 item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_tready = !vld_reg || advance;
    assign vld_next = s_tready ? s_tvalid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_tdata[$bits(item_t)-1:0];
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

/* rtl/core/hdu_core.sv */
// ----------------------------------------------------------------------------
// hdu_core
// Bit timer, transmit framer and receive sampler; one tick per consumed item.
// ----------------------------------------------------------------------------
module hdu_core
    import hdu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    input  logic                 advance,
    input  item_t                item,
    output result_t              result
);

    logic [TICK_W-1:0]  bit_ticks_reg;
    logic [TICK_W-1:0]  half_ticks_reg;

    logic [MODE_W-1:0]  mode_reg,     mode_next;
    logic [TICK_W-1:0]  tick_reg,     tick_next;
    logic [CNT_W-1:0]   left_reg,     left_next;
    logic [FRAME_W-1:0] tx_shift_reg, tx_shift_next;
    logic [FRAME_W-1:0] rx_shift_reg, rx_shift_next;
    logic               line_reg,     line_next;
    logic               prev_reg,     prev_next;
    logic [BYTE_W-1:0]  hold_reg,     hold_next;

    logic [TICK_W-1:0]  interval;
    logic [TICK_W:0]    tick_inc;
    logic               fire;
    logic [CNT_W-1:0]   left_dec;
    logic               good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg  <= BIT_TICKS_RST;
            half_ticks_reg <= HALF_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIT_TICKS:  bit_ticks_reg  <= cfg_data;
                REG_HALF_TICKS: half_ticks_reg <= cfg_data;
                default:        bit_ticks_reg  <= bit_ticks_reg;
            endcase
        end
    end

    // first receive interval runs to the middle of the start bit
    assign interval = (mode_reg == MODE_RX && left_reg == RX_SAMPLES) ? half_ticks_reg
                                                                      : bit_ticks_reg;
    assign tick_inc = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign fire     = tick_inc >= {1'b0, interval};
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        left_next     = left_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        line_next     = line_reg;
        hold_next     = hold_reg;
        prev_next     = item.rx_level;
        good          = 1'b0;

        if (mode_reg != MODE_RX && prev_reg && !item.rx_level)
        begin
            // start edge: abort any send, begin reception
            mode_next     = MODE_RX;
            line_next     = 1'b1;
            tick_next     = '0;
            rx_shift_next = '0;
            left_next     = RX_SAMPLES;
        end
        else if (mode_reg == MODE_RX)
        begin
            tick_next = fire ? '0 : tick_inc[TICK_W-1:0];
            if (fire)
            begin
                rx_shift_next = {item.rx_level, rx_shift_reg[FRAME_W-1:1]};
                left_next     = left_dec;
                if (left_dec == '0)
                begin
                    mode_next = MODE_IDLE;
                    if ((rx_shift_next & FRAME_MASK) == STOP_MARK)
                    begin
                        hold_next = rx_shift_next[BYTE_W:1];
                        good      = 1'b1;
                    end
                end
            end
        end
        else if (mode_reg == MODE_TX)
        begin
            tick_next = fire ? '0 : tick_inc[TICK_W-1:0];
            if (fire)
            begin
                // first event is a guard bit time with the line left high
                if (left_reg != TX_STEPS)
                begin
                    line_next     = tx_shift_reg[0];
                    tx_shift_next = {1'b0, tx_shift_reg[FRAME_W-1:1]};
                end
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    mode_next = MODE_IDLE;
                end
            end
        end
        else
        begin
            mode_next = MODE_IDLE;
            if (item.send)
            begin
                mode_next     = MODE_TX;
                tx_shift_next = {1'b1, item.send_byte, 1'b0};
                left_next     = TX_STEPS;
                tick_next     = '0;
                line_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            tick_reg     <= '0;
            left_reg     <= '0;
            tx_shift_reg <= '0;
            rx_shift_reg <= '0;
            line_reg     <= 1'b1;
            prev_reg     <= 1'b1;
            hold_reg     <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            left_reg     <= left_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            line_reg     <= line_next;
            prev_reg     <= prev_next;
            hold_reg     <= hold_next;
        end
    end

    assign result.tx_level = line_next;
    assign result.tx_busy  = (mode_next == MODE_TX);
    assign result.rx_busy  = (mode_next == MODE_RX);
    assign result.rx_valid = good;
    assign result.rx_byte  = hold_next;

endmodule

/* rtl/core/hdu_out_stage.sv */
// ----------------------------------------------------------------------------
// hdu_out_stage
// Result register towards the master side; frees itself as it is taken.
// ----------------------------------------------------------------------------
module hdu_out_stage
    import hdu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_vld,
    input  result_t                result,
    output logic                   advance,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;
    logic    room;

    assign room     = !vld_reg || m_tready;
    assign advance  = item_vld && room;
    assign vld_next = room ? item_vld : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_reg};

endmodule

/* rtl/core/half_duplex_uart_8n1.sv */
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1
// Tick-stepped half-duplex 8N1 UART: each slave transaction is one timer tick.
//
//  channel   dir  handshake           content
//  s_*       in   tvalid/tready       tick item: receive level, send request, byte
//  m_*       out  tvalid/tready       line state after the tick
//  cfg_*     in   write enable only   bit_ticks (0), half_bit_ticks (1)
//
//  One transaction per clock while m_tready keeps the result register free;
//  each result passes the input register, then the result register, to m_*.
//  The tick logic between the two registers is one 16-bit add and compare.
//  Reset (rst_n, async) clears both stages and puts the line at idle mark.
//  A stalled master side holds the result and freezes the core; with the
//  input register full s_tready drops in the same cycle, with it empty one
//  more transaction is taken first.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1
    import hdu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TICK_W-1:0]      cfg_data,
    // tick items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // rx_level, send, send_byte[7:0], zero pad
    // per-tick results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // tx_level, tx_busy, rx_busy, rx_valid,
                                              // rx_byte[7:0], zero pad
);

    item_t   item;
    logic    item_vld;
    logic    advance;   // held item processed and result register loaded
    result_t result;

    hdu_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    // timer, framer and sampler state advance only on a consumed tick
    hdu_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    hdu_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/core/hdu_checker.sv */
// ----------------------------------------------------------------------------
// hdu_checker
// Port-level checks of the UART, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdu_checker
    import hdu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ASSERT_IMPLY(a_half_duplex, clk, rst_n, m_tvalid, !(m_tdata[1] && m_tdata[2]), "transmit and receive both busy")
    `ASSERT_IMPLY(a_good_ends_rx, clk, rst_n, m_tvalid && m_tdata[3], !m_tdata[2], "byte reported while still receiving")
    `ASSERT_IMPLY(a_mark_when_free, clk, rst_n, m_tvalid && !m_tdata[1], m_tdata[0], "line low outside a transmission")

endmodule

bind half_duplex_uart_8n1 hdu_checker u_hdu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
